// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/slc_pkg.sv =====
// shared constants, word types and rounding helpers for the sector line converter
// no dependencies
package slc_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int GAIN_BITS     = 32;
    localparam int XW            = 2 * WORD_BITS + 2;
    localparam int VR_LIMIT      = 10000;
    localparam int ROOT2_LO_BITS = 31;
    // sqrt2 in q32 minus 2^32
    localparam logic [ROOT2_LO_BITS-1:0] ROOT2_LO = 31'd1779033704;

    localparam int DIV_NW = WORD_BITS + GAIN_BITS + 1;
    localparam int DIV_DW = WORD_BITS + GAIN_BITS - FRAC_BITS;
    localparam int CLP_NW = WORD_BITS + FRAC_BITS + 1;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [XW-1:0]        wide_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // sign codes of the sector cos / sin
    localparam logic [1:0] SGN_ZERO = 2'b00;
    localparam logic [1:0] SGN_POS  = 2'b01;
    localparam logic [1:0] SGN_NEG  = 2'b10;

    localparam logic [1:0] COS_TAB [8] = '{SGN_POS, SGN_POS, SGN_ZERO, SGN_NEG,
                                           SGN_NEG, SGN_NEG, SGN_ZERO, SGN_POS};
    localparam logic [1:0] SIN_TAB [8] = '{SGN_ZERO, SGN_POS, SGN_POS, SGN_POS,
                                           SGN_ZERO, SGN_NEG, SGN_NEG, SGN_NEG};

    typedef struct packed {
        logic [2:0] seg;
        word_t      phi_slope;
        word_t      rad_slope;
        word_t      phi_icpt;
        word_t      rad_icpt;
    } track_t;

    typedef struct packed {
        word_t slope_zx;
        word_t slope_zy;
        word_t icpt_zx;
        word_t icpt_zy;
        logic  parallel;
        logic  div_fault;
    } result_t;

    typedef struct packed {
        word_t phi_slope;
        word_t phi_icpt;
    } slope_side_t;

    typedef struct packed {
        word_t rad_icpt;
        logic  parallel;
        logic  clamp;
    } icpt_side_t;

    typedef struct packed {
        word_t sx;
        word_t sy;
        word_t ix;
        word_t iy_nc;
        word_t iy_c;
        logic  parallel;
        logic  clamp;
        logic  ks_zero;
        logic  num_neg;
        logic  num_zero;
    } back_side_t;

    // saturate a sign / magnitude pair to one word
    function automatic word_t sat_mag(input logic [XW-1:0] mag, input logic neg);
        logic [XW-1:0] max_mag;
        logic [XW-1:0] neg_val;
        max_mag = (XW'(1) << (WORD_BITS - 1)) - XW'(1);
        neg_val = ~mag + XW'(1);
        if (!neg) begin
            sat_mag = (mag > max_mag) ? WORD_MAX : word_t'(mag[WORD_BITS-1:0]);
        end
        else begin
            sat_mag = (mag > max_mag + XW'(1)) ? WORD_MIN : word_t'(neg_val[WORD_BITS-1:0]);
        end
    endfunction

    // saturate a wide signed value to one word
    function automatic word_t sat_s(input wide_t v);
        logic [XW-1:0] mag;
        mag   = v[XW-1] ? (~v + XW'(1)) : v;
        sat_s = sat_mag(mag, v[XW-1]);
    endfunction

    // drop the fraction bits, round to nearest, ties away from zero
    function automatic wide_t round_s(input wide_t p);
        logic [XW-1:0] mag;
        mag     = p[XW-1] ? (~p + XW'(1)) : p;
        mag     = (mag + (XW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        round_s = p[XW-1] ? wide_t'(~mag + XW'(1)) : wide_t'(mag);
    endfunction

endpackage

// ===== rtl/slc_front.sv =====
// front stages: sector decode, clamp, gain products and divider operands
// depends on slc_pkg
module slc_front
    import slc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  track_t                track,
    output logic                  out_valid,
    output logic [DIV_NW-1:0]     slope_mag,
    output logic                  slope_neg,
    output logic [DIV_NW-1:0]     icpt_mag,
    output logic                  icpt_neg,
    output logic [DIV_DW-1:0]     den_mag,
    output slope_side_t           slope_side,
    output icpt_side_t            icpt_side
);

    localparam int DSW = WORD_BITS + 2;
    localparam int SNW = DIV_NW + 1;
    localparam logic [XW-1:0] RV_LIM = XW'(VR_LIMIT) << FRAC_BITS;

    typedef struct packed {
        logic                                odd;
        logic [1:0]                          ss;
        logic signed [DSW-1:0]               den;
        logic [WORD_BITS-1:0]                rvm;
        logic [WORD_BITS-1:0]                rim;
        logic                                rneg;
        logic                                rineg;
        logic [WORD_BITS+ROOT2_LO_BITS-1:0]  mr;
        logic [WORD_BITS+ROOT2_LO_BITS-1:0]  mi;
        logic [WORD_BITS-1:0]                dm;
        logic                                dneg;
        logic [DIV_NW-1:0]                   sn;
        logic [DIV_NW-1:0]                   ig;
        logic signed [SNW-1:0]               num;
        logic [DIV_NW-1:0]                   imag;
        logic                                ineg;
        logic                                sneg;
        logic [DIV_DW-1:0]                   dsc;
        word_t                               ks;
        word_t                               ki;
        word_t                               ri;
        logic                                clamp;
        logic                                par;
    } fr_t;

    logic [4:0] vld_reg;
    fr_t s1_reg, s1_next;
    fr_t s2_reg, s2_next;
    fr_t s3_reg, s3_next;
    fr_t s4_reg, s4_next;
    fr_t s5_reg, s5_next;

    logic [1:0]            cs1;
    logic signed [DSW-1:0] one_x;
    logic signed [DSW-1:0] ks_x;
    logic [WORD_BITS-1:0]  rs_mag;
    logic [WORD_BITS-1:0]  ri_mag;
    logic [DSW-1:0]        dabs;
    logic signed [SNW-1:0] ig_s;
    logic signed [SNW-1:0] kt;
    logic [SNW-1:0]        nabs;

    // stage 1: denominator cos + k sin, radial clamp, magnitudes
    always_comb
    begin
        s1_next = '0;
        cs1     = COS_TAB[track.seg];
        one_x   = DSW'(1) <<< FRAC_BITS;
        ks_x    = DSW'(track.phi_slope);
        if (cs1 == SGN_POS)
        begin
            s1_next.den = one_x;
        end
        else if (cs1 == SGN_NEG)
        begin
            s1_next.den = -one_x;
        end
        s1_next.ss = SIN_TAB[track.seg];
        if (s1_next.ss == SGN_POS)
        begin
            s1_next.den = s1_next.den + ks_x;
        end
        else if (s1_next.ss == SGN_NEG)
        begin
            s1_next.den = s1_next.den - ks_x;
        end
        rs_mag = track.rad_slope[WORD_BITS-1] ? (~track.rad_slope + 1'b1) : track.rad_slope;
        ri_mag = track.rad_icpt[WORD_BITS-1] ? (~track.rad_icpt + 1'b1) : track.rad_icpt;
        s1_next.clamp = XW'(rs_mag) > RV_LIM;
        s1_next.rvm   = s1_next.clamp ? RV_LIM[WORD_BITS-1:0] : rs_mag;
        s1_next.rneg  = track.rad_slope[WORD_BITS-1];
        s1_next.rim   = ri_mag;
        s1_next.rineg = track.rad_icpt[WORD_BITS-1];
        s1_next.odd   = track.seg[0];
        s1_next.ks    = track.phi_slope;
        s1_next.ki    = track.phi_icpt;
        s1_next.ri    = track.rad_icpt;
    end

    // stage 2: sqrt2 partial products, denominator magnitude
    always_comb
    begin
        s2_next      = s1_reg;
        s2_next.mr   = s1_reg.rvm * ROOT2_LO;
        s2_next.mi   = s1_reg.rim * ROOT2_LO;
        dabs         = s1_reg.den[DSW-1] ? (~s1_reg.den + 1'b1) : s1_reg.den;
        s2_next.dm   = dabs[WORD_BITS-1:0];
        s2_next.dneg = s1_reg.den[DSW-1];
        s2_next.par  = (s1_reg.den == '0);
    end

    // stage 3: full gain products
    always_comb
    begin
        s3_next    = s2_reg;
        s3_next.sn = (DIV_NW'(s2_reg.rvm) << GAIN_BITS)
                   + (s2_reg.odd ? DIV_NW'(s2_reg.mr) : '0);
        s3_next.ig = (DIV_NW'(s2_reg.rim) << GAIN_BITS)
                   + (s2_reg.odd ? DIV_NW'(s2_reg.mi) : '0);
    end

    // stage 4: intercept numerator r0 gain - k0 sin
    always_comb
    begin
        s4_next = s3_reg;
        ig_s    = $signed({1'b0, s3_reg.ig});
        if (s3_reg.rineg)
        begin
            ig_s = -ig_s;
        end
        kt          = SNW'(s3_reg.ki) <<< GAIN_BITS;
        s4_next.num = ig_s;
        if (s3_reg.ss == SGN_POS)
        begin
            s4_next.num = ig_s - kt;
        end
        else if (s3_reg.ss == SGN_NEG)
        begin
            s4_next.num = ig_s + kt;
        end
    end

    // stage 5: divider operands in sign / magnitude form
    always_comb
    begin
        s5_next      = s4_reg;
        nabs         = s4_reg.num[SNW-1] ? (~s4_reg.num + 1'b1) : s4_reg.num;
        s5_next.imag = nabs[DIV_NW-1:0];
        s5_next.ineg = s4_reg.num[SNW-1] ^ s4_reg.dneg;
        s5_next.sneg = s4_reg.rneg ^ s4_reg.dneg;
        s5_next.dsc  = DIV_DW'(s4_reg.dm) << (GAIN_BITS - FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        s4_reg <= s4_next;
        s5_reg <= s5_next;
    end

    assign out_valid            = vld_reg[4];
    assign slope_mag            = s5_reg.sn;
    assign slope_neg            = s5_reg.sneg;
    assign icpt_mag             = s5_reg.imag;
    assign icpt_neg             = s5_reg.ineg;
    assign den_mag              = s5_reg.dsc;
    assign slope_side.phi_slope = s5_reg.ks;
    assign slope_side.phi_icpt  = s5_reg.ki;
    assign icpt_side.rad_icpt   = s5_reg.ri;
    assign icpt_side.parallel   = s5_reg.par;
    assign icpt_side.clamp      = s5_reg.clamp;

endmodule

// ===== rtl/slc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, rounded and saturated
// depends on slc_pkg
module slc_div
    import slc_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW,
    parameter int SW = 1
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num_mag,
    input  logic [DW-1:0] den_mag,
    input  logic          quo_neg,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output word_t         quo,
    output logic [SW-1:0] side_out
);

    localparam int QW = WORD_BITS;
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] rem_reg  [0:QW];
    logic [QW-1:0] q_reg    [0:QW];
    logic [DW-1:0] d_reg    [0:QW];
    logic          neg_reg  [0:QW];
    logic          ovf_reg  [0:QW];
    logic          vld_reg  [0:QW];
    logic [SW-1:0] side_reg [0:QW];

    logic          out_vld_reg;
    word_t         quo_reg;
    logic [SW-1:0] side_o_reg;

    logic [CW:0]   rem2;
    logic          rnd;
    logic [QW:0]   qmag;

    // entry: register the operands, flag a quotient too wide for the quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= CW'(num_mag);
        q_reg[0]    <= '0;
        d_reg[0]    <= den_mag;
        neg_reg[0]  <= quo_neg;
        ovf_reg[0]  <= CW'(num_mag) >= (CW'(den_mag) << QW);
        side_reg[0] <= side_in;
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        localparam int SH = QW - k;
        logic [CW-1:0] dsh;
        logic          ge;

        assign dsh = CW'(d_reg[k-1]) << SH;
        assign ge  = rem_reg[k-1] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? (rem_reg[k-1] - dsh) : rem_reg[k-1];
            q_reg[k]    <= q_reg[k-1] | (ge ? (QW'(1) << SH) : '0);
            d_reg[k]    <= d_reg[k-1];
            neg_reg[k]  <= neg_reg[k-1];
            ovf_reg[k]  <= ovf_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    // round on twice the remainder, then saturate
    assign rem2 = {rem_reg[QW], 1'b0};
    assign rnd  = rem2 >= (CW+1)'(d_reg[QW]);
    assign qmag = {1'b0, q_reg[QW]} + (QW+1)'(rnd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg    <= ovf_reg[QW] ? sat_mag('1, neg_reg[QW])
                                  : sat_mag(XW'(qmag), neg_reg[QW]);
        side_o_reg <= side_reg[QW];
    end

    assign out_valid = out_vld_reg;
    assign quo       = quo_reg;
    assign side_out  = side_o_reg;

endmodule

// ===== rtl/slc_mul.sv =====
// middle stages: zy products, clamp-path intercept and second divider operands
// depends on slc_pkg
module slc_mul
    import slc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  word_t                 sx,
    input  word_t                 ix,
    input  slope_side_t           slope_side,
    input  icpt_side_t            icpt_side,
    output logic                  out_valid,
    output logic [CLP_NW-1:0]     num_mag,
    output logic [WORD_BITS-1:0]  ks_mag,
    output logic                  quo_neg,
    output back_side_t            back_side
);

    typedef struct packed {
        word_t                          ks;
        word_t                          ki;
        word_t                          ri;
        word_t                          sx;
        word_t                          ix;
        logic                           par;
        logic                           clamp;
        logic signed [2*WORD_BITS-1:0]  psy;
        logic signed [2*WORD_BITS-1:0]  piy;
        logic signed [2*WORD_BITS-1:0]  pc;
        word_t                          sy;
        word_t                          iy_nc;
        word_t                          iy_c;
        wide_t                          iyr;
    } md_t;

    logic [4:0] vld_reg;
    md_t m1_reg, m1_next;
    md_t m2_reg, m2_next;
    md_t m3_reg, m3_next;
    md_t m4_reg, m4_next;

    logic signed [WORD_BITS:0] diff;
    logic [WORD_BITS:0]        dabs;
    logic [CLP_NW-1:0]         num_mag_reg, num_mag_next;
    logic [WORD_BITS-1:0]      ks_mag_reg, ks_mag_next;
    logic                      quo_neg_reg, quo_neg_next;
    back_side_t                bside_reg, bside_next;

    // products with the phi slope
    always_comb
    begin
        m1_next       = '0;
        m1_next.ks    = slope_side.phi_slope;
        m1_next.ki    = slope_side.phi_icpt;
        m1_next.ri    = icpt_side.rad_icpt;
        m1_next.par   = icpt_side.parallel;
        m1_next.clamp = icpt_side.clamp;
        m1_next.sx    = sx;
        m1_next.ix    = ix;
        m1_next.psy   = slope_side.phi_slope * sx;
        m1_next.piy   = slope_side.phi_slope * ix;
    end

    always_comb
    begin
        m2_next     = m1_reg;
        m2_next.sy  = sat_s(round_s(wide_t'(m1_reg.psy)));
        m2_next.iyr = round_s(wide_t'(m1_reg.piy));
    end

    // unclamped zy intercept, clamp-path product
    always_comb
    begin
        m3_next       = m2_reg;
        m3_next.iy_nc = sat_s(m2_reg.iyr + wide_t'(m2_reg.ki));
        m3_next.pc    = m2_reg.sy * m2_reg.ri;
    end

    always_comb
    begin
        m4_next      = m3_reg;
        m4_next.iy_c = sat_s(-round_s(wide_t'(m3_reg.pc)));
    end

    // (y0 - k0) scaled, divided by the phi slope next
    always_comb
    begin
        diff                = (WORD_BITS+1)'(m4_reg.iy_c) - (WORD_BITS+1)'(m4_reg.ki);
        dabs                = diff[WORD_BITS] ? (~diff + 1'b1) : diff;
        num_mag_next        = {dabs, {FRAC_BITS{1'b0}}};
        ks_mag_next         = m4_reg.ks[WORD_BITS-1] ? (~m4_reg.ks + 1'b1) : m4_reg.ks;
        quo_neg_next        = diff[WORD_BITS] ^ m4_reg.ks[WORD_BITS-1];
        bside_next.sx       = m4_reg.sx;
        bside_next.sy       = m4_reg.sy;
        bside_next.ix       = m4_reg.ix;
        bside_next.iy_nc    = m4_reg.iy_nc;
        bside_next.iy_c     = m4_reg.iy_c;
        bside_next.parallel = m4_reg.par;
        bside_next.clamp    = m4_reg.clamp;
        bside_next.ks_zero  = (m4_reg.ks == '0);
        bside_next.num_neg  = diff[WORD_BITS];
        bside_next.num_zero = (diff == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg      <= m1_next;
        m2_reg      <= m2_next;
        m3_reg      <= m3_next;
        m4_reg      <= m4_next;
        num_mag_reg <= num_mag_next;
        ks_mag_reg  <= ks_mag_next;
        quo_neg_reg <= quo_neg_next;
        bside_reg   <= bside_next;
    end

    assign out_valid = vld_reg[4];
    assign num_mag   = num_mag_reg;
    assign ks_mag    = ks_mag_reg;
    assign quo_neg   = quo_neg_reg;
    assign back_side = bside_reg;

endmodule

// ===== rtl/sector_line_to_cartesian_top.sv =====
// the result strobe done follows an accepted word through the front stages, the two
// 34-stage dividers in series with the middle stages between them, and the result register
// throughput: one word per cycle, busy stays low; results cannot be held off
// reset: rst_n asynchronous active low clears all valid bits, no words in flight
// depends on slc_pkg, slc_front, slc_div, slc_mul and assert_macros.svh
`include "assert_macros.svh"

module sector_line_to_cartesian_top
    import slc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  track_t  track,
    output logic    done,
    output result_t result
);

    localparam int LATENCY = 2 * WORD_BITS + 15;

    // front to first dividers
    logic              f_vld;
    logic [DIV_NW-1:0] f_slope_mag;
    logic              f_slope_neg;
    logic [DIV_NW-1:0] f_icpt_mag;
    logic              f_icpt_neg;
    logic [DIV_DW-1:0] f_den_mag;
    slope_side_t       f_slope_side;
    icpt_side_t        f_icpt_side;

    // first dividers to middle stages
    logic              ds_vld;
    logic              di_vld;
    word_t             ds_quo;
    word_t             di_quo;
    slope_side_t       ds_side;
    icpt_side_t        di_side;

    // middle stages to clamp-path divider
    logic                 m_vld;
    logic [CLP_NW-1:0]    m_num_mag;
    logic [WORD_BITS-1:0] m_ks_mag;
    logic                 m_quo_neg;
    back_side_t           m_side;

    logic       dc_vld;
    word_t      dc_quo;
    back_side_t dc_side;

    logic    done_reg;
    result_t result_reg, result_next;

    // no stall anywhere in the pipe
    assign busy = 1'b0;

    // sector decode, clamp of steep radial slope, gain products
    slc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .track      (track),
        .out_valid  (f_vld),
        .slope_mag  (f_slope_mag),
        .slope_neg  (f_slope_neg),
        .icpt_mag   (f_icpt_mag),
        .icpt_neg   (f_icpt_neg),
        .den_mag    (f_den_mag),
        .slope_side (f_slope_side),
        .icpt_side  (f_icpt_side)
    );

    // zx slope: clamped radial slope over the sector denominator
    slc_div #(
        .NW (DIV_NW),
        .DW (DIV_DW),
        .SW ($bits(slope_side_t))
    ) u_div_slope (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_vld),
        .num_mag   (f_slope_mag),
        .den_mag   (f_den_mag),
        .quo_neg   (f_slope_neg),
        .side_in   (f_slope_side),
        .out_valid (ds_vld),
        .quo       (ds_quo),
        .side_out  (ds_side)
    );

    // zx intercept on the unclamped path
    slc_div #(
        .NW (DIV_NW),
        .DW (DIV_DW),
        .SW ($bits(icpt_side_t))
    ) u_div_icpt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_vld),
        .num_mag   (f_icpt_mag),
        .den_mag   (f_den_mag),
        .quo_neg   (f_icpt_neg),
        .side_in   (f_icpt_side),
        .out_valid (di_vld),
        .quo       (di_quo),
        .side_out  (di_side)
    );

    // zy slope and intercepts, operands of the clamp-path division
    slc_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (ds_vld && di_vld),
        .sx         (ds_quo),
        .ix         (di_quo),
        .slope_side (ds_side),
        .icpt_side  (di_side),
        .out_valid  (m_vld),
        .num_mag    (m_num_mag),
        .ks_mag     (m_ks_mag),
        .quo_neg    (m_quo_neg),
        .back_side  (m_side)
    );

    // clamp path: x0 = (y0 - k0) / vk
    slc_div #(
        .NW (CLP_NW),
        .DW (WORD_BITS),
        .SW ($bits(back_side_t))
    ) u_div_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_vld),
        .num_mag   (m_num_mag),
        .den_mag   (m_ks_mag),
        .quo_neg   (m_quo_neg),
        .side_in   (m_side),
        .out_valid (dc_vld),
        .quo       (dc_quo),
        .side_out  (dc_side)
    );

    // pick the path, parallel track forces all zero
    always_comb
    begin
        result_next = result_reg;
        if (dc_vld)
        begin
            if (dc_side.parallel)
            begin
                result_next          = '0;
                result_next.parallel = 1'b1;
            end
            else if (!dc_side.clamp)
            begin
                result_next.slope_zx  = dc_side.sx;
                result_next.slope_zy  = dc_side.sy;
                result_next.icpt_zx   = dc_side.ix;
                result_next.icpt_zy   = dc_side.iy_nc;
                result_next.parallel  = 1'b0;
                result_next.div_fault = 1'b0;
            end
            else
            begin
                result_next.slope_zx = dc_side.sx;
                result_next.slope_zy = dc_side.sy;
                result_next.icpt_zy  = dc_side.iy_c;
                result_next.parallel = 1'b0;
                // zero phi slope: saturate by the numerator sign
                if (dc_side.ks_zero)
                begin
                    result_next.div_fault = 1'b1;
                    if (dc_side.num_zero)
                    begin
                        result_next.icpt_zx = '0;
                    end
                    else
                    begin
                        result_next.icpt_zx = dc_side.num_neg ? WORD_MIN : WORD_MAX;
                    end
                end
                else
                begin
                    result_next.div_fault = 1'b0;
                    result_next.icpt_zx   = dc_quo;
                end
            end
        end
    end

    // result word held between strobes, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg   <= dc_vld;
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_IMP(a_latency, clk, rst_n, start && !busy, ##LATENCY done, "result word missing at fixed latency")
    `ASSERT_IMP(a_par_zero, clk, rst_n, done && result.parallel, result.slope_zx == '0 && result.slope_zy == '0 && result.icpt_zx == '0 && result.icpt_zy == '0 && !result.div_fault, "parallel word not cleared")
    `ASSERT_NXT(a_hold, clk, rst_n, !dc_vld, $stable(result), "result changed without a new word")
    `ASSERT_IMP(a_fault_clamp, clk, rst_n, dc_vld && !dc_side.clamp, !result_next.div_fault, "divide fault outside the clamp path")

endmodule

// ===== tb/testbench.sv =====
// self-checking bench for sector_line_to_cartesian_top: directed table, then random tracks
// depends on slc_pkg and the rtl top level
`timescale 1ns / 100ps

module testbench
    import slc_pkg::*;
();

    localparam int LATENCY   = 2 * WORD_BITS + 15;
    localparam int N_RANDOM  = 950;
    localparam int WDOG_MAX  = 2000;
    localparam longint unsigned ROOT2_Q32 = 64'd6074001000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    track_t  track;
    logic    done;
    result_t result;

    sector_line_to_cartesian_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .track  (track),
        .done   (done),
        .result (result)
    );

    // expected results, oldest first
    result_t pending_results[$];
    int      n_errors;
    int      n_checked;
    int      n_parallel;
    int      n_fault;
    int      idle_cycles;
    bit      timed_out;

    typedef logic signed [255:0] big_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // exact rounding division, to nearest, ties away from zero
    function automatic big_t div_round(input big_t n, input big_t d);
        big_t an;
        big_t ad;
        big_t q;
        big_t r;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q  = an / ad;
        r  = an % ad;
        if (2 * r >= ad)
            q = q + 1;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic big_t shift_round(input big_t p);
        big_t m;
        m = (p < 0) ? -p : p;
        m = (m + (big_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (p < 0) ? -m : m;
    endfunction

    function automatic big_t clip_word(input big_t v);
        if (v > big_t'(WORD_MAX))
            return big_t'(WORD_MAX);
        if (v < big_t'(WORD_MIN))
            return big_t'(WORD_MIN);
        return v;
    endfunction

    // predicts the ZX / ZY projection of one track
    function automatic result_t project_track(input track_t t);
        result_t res;
        big_t    one;
        big_t    den;
        big_t    gain;
        big_t    dsc;
        big_t    lim;
        big_t    rv;
        big_t    ks;
        big_t    ki;
        big_t    ri;
        big_t    sx;
        big_t    sy;
        big_t    ix;
        big_t    iy;
        big_t    num;
        bit      clamp;
        res   = '0;
        one   = big_t'(1) <<< FRAC_BITS;
        ks    = big_t'(t.phi_slope);
        ki    = big_t'(t.phi_icpt);
        ri    = big_t'(t.rad_icpt);
        rv    = big_t'(t.rad_slope);
        den   = 0;
        if (COS_TAB[t.seg] == SGN_POS)
            den = one;
        else if (COS_TAB[t.seg] == SGN_NEG)
            den = -one;
        if (SIN_TAB[t.seg] == SGN_POS)
            den = den + ks;
        else if (SIN_TAB[t.seg] == SGN_NEG)
            den = den - ks;
        if (den == 0)
        begin
            res.parallel = 1'b1;
            return res;
        end
        gain  = t.seg[0] ? big_t'(ROOT2_Q32) : (big_t'(1) <<< GAIN_BITS);
        dsc   = den <<< (GAIN_BITS - FRAC_BITS);
        lim   = big_t'(VR_LIMIT) <<< FRAC_BITS;
        clamp = 1'b0;
        if (rv > lim)
        begin
            rv    = lim;
            clamp = 1'b1;
        end
        else if (rv < -lim)
        begin
            rv    = -lim;
            clamp = 1'b1;
        end
        sx = clip_word(div_round(rv * gain, dsc));
        sy = clip_word(shift_round(ks * sx));
        if (!clamp)
        begin
            num = ri * gain;
            if (SIN_TAB[t.seg] == SGN_POS)
                num = num - (ki <<< GAIN_BITS);
            else if (SIN_TAB[t.seg] == SGN_NEG)
                num = num + (ki <<< GAIN_BITS);
            ix = clip_word(div_round(num, dsc));
            iy = clip_word(shift_round(ks * ix) + ki);
        end
        else
        begin
            iy  = clip_word(-shift_round(sy * ri));
            num = (iy - ki) <<< FRAC_BITS;
            if (ks == 0)
            begin
                res.div_fault = 1'b1;
                ix = (num == 0) ? 0 : ((num < 0) ? big_t'(WORD_MIN) : big_t'(WORD_MAX));
            end
            else
                ix = clip_word(div_round(num, ks));
        end
        res.slope_zx = word_t'(sx);
        res.slope_zy = word_t'(sy);
        res.icpt_zx  = word_t'(ix);
        res.icpt_zy  = word_t'(iy);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        n_errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // result side: every strobe is compared with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word", result.slope_zx, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (want.parallel)
                    n_parallel++;
                if (want.div_fault)
                    n_fault++;
                if (result.slope_zx !== want.slope_zx)
                    report_mismatch("slope_zx", result.slope_zx, want.slope_zx);
                if (result.slope_zy !== want.slope_zy)
                    report_mismatch("slope_zy", result.slope_zy, want.slope_zy);
                if (result.icpt_zx !== want.icpt_zx)
                    report_mismatch("icpt_zx", result.icpt_zx, want.icpt_zx);
                if (result.icpt_zy !== want.icpt_zy)
                    report_mismatch("icpt_zy", result.icpt_zy, want.icpt_zy);
                if (result.parallel !== want.parallel)
                    report_mismatch("parallel", word_t'(result.parallel), word_t'(want.parallel));
                if (result.div_fault !== want.div_fault)
                    report_mismatch("div_fault", word_t'(result.div_fault),
                                    word_t'(want.div_fault));
            end
        end
    end

    // watchdog: cycles with no word accepted on either side end the run at the limit
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("covered %0d tracks checked before the pipe went quiet", n_checked);
            $display("watchdog expired with %0d results outstanding", pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // directed table: a typed-in expectation where it is obvious, else the predictor
    typedef struct {
        track_t  trk;
        bit      typed;
        result_t res;
    } table_row_t;

    table_row_t dir_table[$];

    function automatic word_t q16(input int v);
        return word_t'(v) <<< FRAC_BITS;
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return word_t'($urandom_range(0, 3)) - word_t'(1);
            3: return q16($urandom_range(0, 4)) - q16(2);
            4: return q16(10000) + word_t'($urandom_range(0, 2)) - word_t'(1);
            5: return -q16(10000) + word_t'($urandom_range(0, 2)) - word_t'(1);
            6: return word_t'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic track_t rand_track();
        track_t t;
        t.seg       = 3'($urandom_range(0, 7));
        t.phi_slope = rand_word();
        t.rad_slope = rand_word();
        t.phi_icpt  = rand_word();
        t.rad_icpt  = rand_word();
        // steer some tracks onto the parallel and the zero-slope cases
        if ($urandom_range(0, 15) == 0)
            t.phi_slope = t.seg[0] ? (t.seg[1] ? q16(1) : -q16(1)) : '0;
        return t;
    endfunction

    task automatic add_row(input logic [2:0] s, input word_t k, input word_t r,
                           input word_t ki, input word_t ri, input bit typed,
                           input result_t res);
        table_row_t row;
        row.trk   = '{seg: s, phi_slope: k, rad_slope: r, phi_icpt: ki, rad_icpt: ri};
        row.typed = typed;
        row.res   = res;
        dir_table.insert(dir_table.size(), row);
    endtask

    task automatic send_track(input track_t t, input result_t want);
        start <= 1'b1;
        track <= t;
        pending_results.insert(pending_results.size(), want);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        result_t zero_res;
        result_t par_res;
        result_t typed_res;
        int      burst;
        int      gap;
        int      sent;
        n_errors    = 0;
        n_checked   = 0;
        n_parallel  = 0;
        n_fault     = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        start       = 1'b0;
        track       = '0;
        rst_n       = 1'b0;
        zero_res    = '0;
        par_res     = '0;
        par_res.parallel = 1'b1;

        // sector 0 identity: all zeros in gives all zeros out
        add_row(3'd0, '0, '0, '0, '0, 1'b1, zero_res);
        // sector 0, zero phi slope: D = 1 so the radial terms pass straight through
        typed_res = '0;
        typed_res.slope_zx = q16(2);
        typed_res.icpt_zx  = q16(3);
        typed_res.icpt_zy  = q16(5);
        add_row(3'd0, '0, q16(2), q16(5), q16(3), 1'b1, typed_res);
        // parallel tracks in the sector pairs 1/5, 2/6 and 3/7 (sectors 0 and 4 cannot be parallel)
        add_row(3'd1, -q16(1), q16(7), q16(1), q16(2), 1'b1, par_res);
        add_row(3'd5, -q16(1), WORD_MAX, WORD_MIN, WORD_MAX, 1'b1, par_res);
        add_row(3'd2, '0, q16(3), q16(1), q16(1), 1'b1, par_res);
        add_row(3'd6, '0, WORD_MIN, WORD_MAX, WORD_MIN, 1'b1, par_res);
        add_row(3'd3, q16(1), q16(1), q16(1), q16(1), 1'b1, par_res);
        add_row(3'd7, q16(1), WORD_MAX, '0, '0, 1'b1, par_res);
        // steep radial slope with zero phi slope: divide fault, in both signs and zero
        add_row(3'd0, '0, WORD_MAX, q16(4), q16(1), 1'b0, zero_res);
        add_row(3'd4, '0, WORD_MIN, -q16(4), q16(1), 1'b0, zero_res);
        add_row(3'd0, '0, q16(20000), '0, '0, 1'b0, zero_res);
        // clamp boundary, just at and just past the limit
        add_row(3'd1, q16(2), q16(10000), q16(1), q16(1), 1'b0, zero_res);
        add_row(3'd3, q16(2), q16(10000) + 1, q16(1), q16(1), 1'b0, zero_res);
        add_row(3'd5, q16(2), -q16(10000) - 1, q16(1), q16(1), 1'b0, zero_res);
        // field extremes in each sector
        for (int s = 0; s < 8; s++)
            add_row(3'(s), (s % 2) ? WORD_MAX : WORD_MIN, WORD_MIN, WORD_MAX,
                    (s % 3) ? WORD_MIN : WORD_MAX, 1'b0, zero_res);
        // tiny denominator drives saturation
        add_row(3'd2, 1, q16(100), q16(100), WORD_MAX, 1'b0, zero_res);
        add_row(3'd7, q16(1) + 1, WORD_MAX, WORD_MIN, q16(3), 1'b0, zero_res);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no gaps, running straight into the random part
        foreach (dir_table[i])
            send_track(dir_table[i].trk,
                       dir_table[i].typed ? dir_table[i].res : project_track(dir_table[i].trk));

        // random part: bursts of tracks with random gaps between them
        sent = 0;
        while (sent < N_RANDOM && !timed_out)
        begin
            track_t t;
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < N_RANDOM; b++)
            begin
                t = rand_track();
                send_track(t, project_track(t));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start <= 1'b0;

        // drain, then wait out the pipe latency and a margin to catch stray strobes
        while (pending_results.size() != 0 && idle_cycles < WDOG_MAX)
            @(posedge clk);
        if (pending_results.size() != 0)
            timed_out = 1'b1;
        else
            repeat (LATENCY + 10) @(posedge clk);

        $display("covered %0d tracks checked, %0d parallel, %0d divide faults",
                 n_checked, n_parallel, n_fault);
        if (timed_out)
        begin
            $display("watchdog expired with %0d results outstanding", pending_results.size());
            $display("tb: failure");
        end
        else if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
